// File: rtl/core/fcpa_pkg.sv
package fcpa_pkg;

  localparam int MAX_CHUNKS      = 1024;
  localparam int MAX_CHUNK_BYTES = 4096;
  // A free chunk must be able to hold its link word.
  localparam int LINK_BYTES      = 4;

  localparam int ADDR_W    = $clog2(MAX_CHUNKS);
  localparam int CNT_W     = 11;
  localparam int BYTES_W   = 13;
  localparam int OFF_W     = BYTES_W + CNT_W;
  localparam int ALLOC_W   = 23;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(CNT_W + 1);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_SPACE     = 3'd1;
  localparam logic [2:0] ST_TOO_BIG      = 3'd2;
  localparam logic [2:0] ST_BAD_ALIGN    = 3'd3;
  localparam logic [2:0] ST_OUTSIDE      = 3'd4;
  localparam logic [2:0] ST_NOT_BOUNDARY = 3'd5;
  localparam logic [2:0] ST_DOUBLE_FREE  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [BYTES_W-1:0] request_size;
    logic [BYTES_W-1:0] request_alignment;
    logic [DATA_W-1:0]  free_address;
  } fcpa_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [DATA_W-1:0]  chunk_address;
    logic [CNT_W-1:0]   free_chunks;
    logic               pool_full;
    logic               pool_empty;
    logic [ALLOC_W-1:0] allocated_bytes;
  } fcpa_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } link_cmd_t;

endpackage

// File: rtl/core/fcpa_link_store.sv
module fcpa_link_store import fcpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  link_cmd_t        cmd_i,
  output logic [CNT_W-1:0] rdata_o,
  output logic             busy_o
);

  logic [CNT_W-1:0]  link_mem_q [MAX_CHUNKS];
  logic [CNT_W-1:0]  rdata_q;
  logic              busy_q, busy_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CNT_W-1:0]  wdata;

  // The sweep rewrites the whole chain, one entry per cycle, so that entry i
  // links to i+1. A new clear request restarts it from entry zero.
  always_comb begin
    busy_d = busy_q;
    ptr_d  = ptr_q;
    if (clear_i) begin
      busy_d = 1'b1;
      ptr_d  = '0;
    end else if (busy_q) begin
      ptr_d = ptr_q + 1'b1;
      if (ptr_q == ADDR_W'(MAX_CHUNKS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      ptr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ptr_q  <= ptr_d;
    end
  end

  assign we    = busy_q ? 1'b1 : cmd_i.we;
  assign waddr = busy_q ? ptr_q : cmd_i.waddr;
  assign wdata = busy_q ? (CNT_W'(ptr_q) + 1'b1) : cmd_i.wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      link_mem_q[waddr] <= wdata;
    end
    if (cmd_i.re) begin
      rdata_q <= link_mem_q[cmd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// File: rtl/core/fcpa_divider.sv
module fcpa_divider import fcpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [OFF_W-1:0]   dividend_i,
  input  logic [BYTES_W-1:0] divisor_i,
  output logic               done_o,
  output logic [CNT_W-1:0]   quot_o,
  output logic               rem_nz_o
);

  logic                 run_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [BYTES_W-1:0]   rem_q;
  logic [CNT_W-1:0]     quo_q;
  logic [BYTES_W:0]     trial;
  logic                 ge;

  // The dividend is below divisor times 2^CNT_W, so its upper part already
  // sits below the divisor and only CNT_W quotient bits remain to be found.
  assign trial = {rem_q, quo_q[CNT_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(CNT_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= BYTES_W'(dividend_i >> CNT_W);
      quo_q <= dividend_i[CNT_W-1:0];
    end else if (run_q) begin
      rem_q <= ge ? BYTES_W'(trial - {1'b0, divisor_i}) : trial[BYTES_W-1:0];
      quo_q <= {quo_q[CNT_W-2:0], ge};
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quo_q;
  assign rem_nz_o = rem_q != '0;

endmodule

// File: rtl/core/fixed_chunk_pool_allocator_core.sv
// Chunk pool allocator with a linked free list held in a 1024-entry RAM.
// Requests arrive on the in_* valid/ready channel (allocate, free or
// rebuild), and every request beat yields exactly one result beat on the
// out_* valid/ready channel carrying status, chunk address and occupancy.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write them only while idle, which the block itself does not enforce. Writing
// the base, chunk size or chunk count rebuilds the pool. Rebuild, unknown,
// refused allocate and out-of-pool free requests go from the execute state
// straight to the done state; an allocate that pops a chunk passes a read state
// for the link RAM read, and a free that lies inside the pool waits in a divide
// state on the 11-step restoring divider that turns the address offset into a
// chunk index. One request is in work at a time; the next is taken only once
// the result is loaded and the block is back in idle.
// After reset, after a rebuild request and after a geometry write, a
// clearing pass rewrites the link RAM one entry per cycle; in_ready_o stays low
// meanwhile, while register writes are still taken.
// The result register decouples the two sides: a new request is accepted
// while an earlier result waits, and a finished request waits for the
// result register before it updates the pool, so nothing is lost.
module fixed_chunk_pool_allocator_core import fcpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fcpa_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fcpa_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_PUSH    = 2'd2;
  localparam logic [1:0] ACT_REBUILD = 2'd3;

  logic [DATA_W-1:0]  cfg_base_q;
  logic [BYTES_W-1:0] cfg_bytes_q, cfg_align_q;
  logic [CNT_W-1:0]   cfg_count_q;
  logic [BYTES_W-1:0] size_eff_q, size_eff_d;
  logic [CNT_W-1:0]   count_eff_q, count_eff_d;
  logic [OFF_W-1:0]   span_q;

  logic [2:0]         state_q, state_d;
  fcpa_in_t           item_q, item_d;
  logic [1:0]         act_q, act_d;
  logic [2:0]         status_q, status_d;
  logic [DATA_W-1:0]  addr_q, addr_d;
  logic [OFF_W-1:0]   prod_q, prod_d;
  logic [CNT_W-1:0]   link_q, link_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   nf_q, nf_d;
  logic [CNT_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   free_q, free_d;
  logic               out_valid_q, out_valid_d;
  fcpa_out_t          out_q, out_d;

  link_cmd_t          link_cmd;
  logic [CNT_W-1:0]   link_rdata;
  logic               clr_busy;
  logic               clr_start;
  logic               rebuild_go;

  logic               div_start, div_done, div_rem_nz;
  logic [CNT_W-1:0]   div_quot;

  logic [DATA_W-1:0]  diff;
  logic               outside;
  logic [CNT_W-1:0]   used;
  logic [OFF_W-1:0]   alloc_prod;

  // Effective geometry, clamped to what the pool can represent.
  always_comb begin
    if (cfg_bytes_q < BYTES_W'(LINK_BYTES)) begin
      size_eff_d = BYTES_W'(LINK_BYTES);
    end else if (cfg_bytes_q > BYTES_W'(MAX_CHUNK_BYTES)) begin
      size_eff_d = BYTES_W'(MAX_CHUNK_BYTES);
    end else begin
      size_eff_d = cfg_bytes_q;
    end
    if (cfg_count_q == '0) begin
      count_eff_d = CNT_W'(1);
    end else if (cfg_count_q > CNT_W'(MAX_CHUNKS)) begin
      count_eff_d = CNT_W'(MAX_CHUNKS);
    end else begin
      count_eff_d = cfg_count_q;
    end
  end

  // Geometry only changes together with a clearing pass, so these derived
  // values settle long before the next request is accepted.
  always_ff @(posedge clk_i) begin
    size_eff_q  <= size_eff_d;
    count_eff_q <= count_eff_d;
    span_q      <= OFF_W'(size_eff_q) * OFF_W'(count_eff_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= '0;
      cfg_bytes_q <= BYTES_W'(64);
      cfg_count_q <= CNT_W'(1024);
      cfg_align_q <= BYTES_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE:  cfg_base_q  <= cfg_wdata_i;
        CFG_BYTES: cfg_bytes_q <= cfg_wdata_i[BYTES_W-1:0];
        CFG_COUNT: cfg_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_ALIGN: cfg_align_q <= cfg_wdata_i[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign clr_start = rebuild_go || (cfg_we_i && (cfg_idx_i != CFG_ALIGN));

  fcpa_link_store u_link_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clr_start),
    .cmd_i   (link_cmd),
    .rdata_o (link_rdata),
    .busy_o  (clr_busy)
  );

  assign diff    = item_q.free_address - cfg_base_q;
  assign outside = (item_q.free_address < cfg_base_q) || (diff >= DATA_W'(span_q));

  fcpa_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff[OFF_W-1:0]),
    .divisor_i  (size_eff_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  assign used       = (nf_q <= count_eff_q) ? (count_eff_q - nf_q) : '0;
  assign alloc_prod = OFF_W'(size_eff_q) * OFF_W'(used);
  assign in_ready_o = (state_q == S_IDLE) && !clr_busy;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    act_d       = act_q;
    status_d    = status_q;
    addr_d      = addr_q;
    prod_d      = prod_q;
    link_d      = link_q;
    idx_d       = idx_q;
    nf_d        = nf_q;
    head_d      = head_q;
    free_d      = free_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    div_start   = 1'b0;
    rebuild_go  = 1'b0;
    link_cmd    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    // While the chain is being rebuilt the list starts over at chunk zero.
    if (clr_busy) begin
      head_d = '0;
      free_d = count_eff_q;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        act_d    = ACT_NONE;
        status_d = ST_OK;
        addr_d   = '0;
        nf_d     = free_q;
        state_d  = S_DONE;
        case (item_q.operation)
          OP_ALLOC: begin
            if (item_q.request_size > size_eff_q) begin
              status_d = ST_TOO_BIG;
            end else if (item_q.request_alignment != cfg_align_q) begin
              status_d = ST_BAD_ALIGN;
            end else if ((free_q == '0) || (head_q >= count_eff_q)) begin
              status_d = ST_NO_SPACE;
            end else begin
              act_d          = ACT_POP;
              nf_d           = free_q - 1'b1;
              link_cmd.re    = 1'b1;
              link_cmd.raddr = head_q[ADDR_W-1:0];
              prod_d         = OFF_W'(head_q) * OFF_W'(size_eff_q);
              state_d        = S_READ;
            end
          end
          OP_FREE: begin
            if (outside) begin
              status_d = ST_OUTSIDE;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OP_REBUILD: begin
            act_d = ACT_REBUILD;
            nf_d  = count_eff_q;
          end
          default: ;
        endcase
      end
      S_READ: begin
        link_d  = link_rdata;
        addr_d  = cfg_base_q + DATA_W'(prod_q);
        state_d = S_DONE;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
          if (div_rem_nz) begin
            status_d = ST_NOT_BOUNDARY;
          end else if ((div_quot == head_q) || (free_q >= count_eff_q) ||
                       (div_quot >= CNT_W'(MAX_CHUNKS))) begin
            status_d = ST_DOUBLE_FREE;
          end else begin
            act_d = ACT_PUSH;
            idx_d = div_quot;
            nf_d  = free_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        // The pool is only updated once the result has a place to go.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.status          = status_q;
          out_d.chunk_address   = addr_q;
          out_d.free_chunks     = nf_q;
          out_d.pool_full       = nf_q == '0;
          out_d.pool_empty      = nf_q == count_eff_q;
          out_d.allocated_bytes = alloc_prod[ALLOC_W-1:0];
          case (act_q)
            ACT_POP: begin
              head_d = link_q;
              free_d = nf_q;
            end
            ACT_PUSH: begin
              link_cmd.we    = 1'b1;
              link_cmd.waddr = idx_q[ADDR_W-1:0];
              link_cmd.wdata = head_q;
              head_d         = idx_q;
              free_d         = nf_q;
            end
            ACT_REBUILD: rebuild_go = 1'b1;
            default: ;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      free_q      <= CNT_W'(MAX_CHUNKS);
      act_q       <= ACT_NONE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      free_q      <= free_d;
      act_q       <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    prod_q   <= prod_d;
    link_q   <= link_d;
    idx_q    <= idx_d;
    nf_q     <= nf_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clr_busy && (state_q == S_IDLE)) |-> (free_q <= count_eff_q))
    else $error("free chunk total exceeds the chunk count");

  a_pop_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (head_q < count_eff_q))
    else $error("link read issued for a head outside the pool");

  a_rebuild_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (act_q == ACT_REBUILD) && (!out_valid_q || out_ready_i))
    |=> (clr_busy && !in_ready_o))
    else $error("rebuild result did not start the clearing pass");

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fcpa_pkg::*;

  // The package names only the three defined operations.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    logic [DATA_W-1:0]  base;
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   count;
    logic [BYTES_W-1:0] align;
  } pool_cfg_t;

  typedef struct {
    row_kind_e kind;
    pool_cfg_t geo;
    fcpa_in_t  item;
    bit        typed;
    fcpa_out_t result;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  fcpa_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  fcpa_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  // Shadow of the pool as the block should hold it.
  logic [CNT_W-1:0]   link_mem [MAX_CHUNKS];
  logic [CNT_W-1:0]   free_head;
  logic [CNT_W-1:0]   free_cnt;
  logic [DATA_W-1:0]  cfg_base;
  logic [BYTES_W-1:0] cfg_bytes;
  logic [CNT_W-1:0]   cfg_count;
  logic [BYTES_W-1:0] cfg_align;

  fcpa_out_t         result_fifo[$];
  logic [DATA_W-1:0] live_chunks[$];
  dir_row_t          dir_tab[$];
  int                mismatches = 0;
  int                sent_items = 0;
  int                got_results = 0;

  fixed_chunk_pool_allocator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [BYTES_W-1:0] chunk_size();
    if (cfg_bytes < LINK_BYTES) return BYTES_W'(LINK_BYTES);
    if (cfg_bytes > MAX_CHUNK_BYTES) return BYTES_W'(MAX_CHUNK_BYTES);
    return cfg_bytes;
  endfunction

  function automatic logic [CNT_W-1:0] pool_chunks();
    if (cfg_count < 1) return CNT_W'(1);
    if (cfg_count > MAX_CHUNKS) return CNT_W'(MAX_CHUNKS);
    return cfg_count;
  endfunction

  function automatic void rebuild_pool();
    for (int i = 0; i < MAX_CHUNKS; i++) link_mem[i] = CNT_W'(i + 1);
    free_head = '0;
    free_cnt = pool_chunks();
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    case (idx)
      CFG_BASE: begin
        cfg_base = val;
        rebuild_pool();
      end
      CFG_BYTES: begin
        cfg_bytes = val[BYTES_W-1:0];
        rebuild_pool();
      end
      CFG_COUNT: begin
        cfg_count = val[CNT_W-1:0];
        rebuild_pool();
      end
      default: cfg_align = val[BYTES_W-1:0];
    endcase
  endfunction

  // Applies one request to the shadow pool and returns the result it should give.
  function automatic fcpa_out_t pool_step(fcpa_in_t it);
    fcpa_out_t        r;
    logic [BYTES_W-1:0] sz;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] used;
    logic [63:0]      span;
    logic [63:0]      off;
    logic [31:0]      delta;
    logic [31:0]      idx;
    sz = chunk_size();
    cnt = pool_chunks();
    r = '0;
    r.status = ST_OK;
    case (it.operation)
      OP_ALLOC: begin
        if (it.request_size > sz) begin
          r.status = ST_TOO_BIG;
        end else if (it.request_alignment != cfg_align) begin
          r.status = ST_BAD_ALIGN;
        end else if (free_cnt == 0 || free_head >= cnt) begin
          r.status = ST_NO_SPACE;
        end else begin
          r.chunk_address = 32'(64'(cfg_base) + 64'(free_head) * 64'(sz));
          free_cnt = free_cnt - 1'b1;
          free_head = link_mem[free_head[ADDR_W-1:0]];
        end
      end
      OP_FREE: begin
        span = 64'(sz) * 64'(cnt);
        delta = it.free_address - cfg_base;
        if (it.free_address < cfg_base || 64'(delta) >= span) begin
          r.status = ST_OUTSIDE;
        end else begin
          off = 64'(delta);
          idx = 32'(off / sz);
          if (off % sz != 0) begin
            r.status = ST_NOT_BOUNDARY;
          end else if (idx == 32'(free_head) || free_cnt >= cnt || idx >= MAX_CHUNKS) begin
            r.status = ST_DOUBLE_FREE;
          end else begin
            link_mem[idx[ADDR_W-1:0]] = free_head;
            free_head = idx[CNT_W-1:0];
            free_cnt = free_cnt + 1'b1;
          end
        end
      end
      OP_REBUILD: rebuild_pool();
      default: ;
    endcase
    used = (free_cnt <= cnt) ? cnt - free_cnt : '0;
    r.free_chunks = free_cnt;
    r.pool_full = (free_cnt == 0);
    r.pool_empty = (free_cnt == cnt);
    r.allocated_bytes = ALLOC_W'(64'(sz) * 64'(used));
    return r;
  endfunction

  function automatic fcpa_out_t outcome(logic [2:0] st, logic [DATA_W-1:0] addr,
                                        int free, bit full, bit empty, int bytes);
    fcpa_out_t r;
    r.status = st;
    r.chunk_address = addr;
    r.free_chunks = CNT_W'(free);
    r.pool_full = full;
    r.pool_empty = empty;
    r.allocated_bytes = ALLOC_W'(bytes);
    return r;
  endfunction

  function automatic dir_row_t item_row(logic [1:0] op, int size, int align,
                                        logic [DATA_W-1:0] addr);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.geo = '{'0, '0, '0, '0};
    row.item.operation = op;
    row.item.request_size = BYTES_W'(size);
    row.item.request_alignment = BYTES_W'(align);
    row.item.free_address = addr;
    row.typed = 1'b0;
    row.result = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic [1:0] op, int size, int align,
                                         logic [DATA_W-1:0] addr, fcpa_out_t r);
    dir_row_t row;
    row = item_row(op, size, align, addr);
    row.typed = 1'b1;
    row.result = r;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [DATA_W-1:0] base, int bytes, int count,
                                       int align);
    dir_row_t row;
    row = item_row(OP_UNKNOWN, 0, 0, '0);
    row.kind = ROW_CFG;
    row.geo = '{base, BYTES_W'(bytes), CNT_W'(count), BYTES_W'(align)};
    return row;
  endfunction

  // Random request, mostly well formed against the current pool so that the
  // free list fills and drains; the rest probes every error path.
  function automatic fcpa_in_t gen_item();
    fcpa_in_t         it;
    int unsigned      pick;
    int unsigned      k;
    int unsigned      slot;
    logic [BYTES_W-1:0] sz;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      addr_span;
    sz = chunk_size();
    cnt = pool_chunks();
    addr_span = 32'(sz) * 32'(cnt);
    it.operation = OP_ALLOC;
    it.request_size = BYTES_W'($urandom());
    it.request_alignment = BYTES_W'($urandom());
    it.free_address = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      it.request_size = BYTES_W'($urandom_range(0, sz));
      it.request_alignment = cfg_align;
      if ($urandom_range(0, 9) == 0) it.request_size = BYTES_W'($urandom_range(sz, 8191));
      if ($urandom_range(0, 9) == 0) it.request_alignment = BYTES_W'($urandom());
    end else if (pick < 84) begin
      it.operation = OP_FREE;
      k = $urandom_range(0, 9);
      if (k < 6 && live_chunks.size() > 0) begin
        slot = $urandom_range(0, live_chunks.size() - 1);
        it.free_address = live_chunks[slot];
        live_chunks.delete(slot);
      end else if (k == 6 && free_head < cnt) begin
        it.free_address = cfg_base + 32'(free_head) * 32'(sz);
      end else if (k == 7) begin
        it.free_address = cfg_base + 32'($urandom_range(0, cnt - 1)) * 32'(sz)
                          + 32'($urandom_range(1, sz - 1));
      end else if (k == 8) begin
        if ($urandom_range(0, 1) == 1) it.free_address = cfg_base - 32'($urandom_range(1, 64));
        else it.free_address = cfg_base + addr_span + 32'($urandom_range(0, 64));
      end else if (k != 9) begin
        it.free_address = cfg_base + 32'($urandom_range(0, cnt - 1)) * 32'(sz);
      end
    end else if (pick < 87) begin
      it.operation = OP_REBUILD;
    end else if (pick < 90) begin
      it.operation = OP_UNKNOWN;
    end else begin
      it.operation = 2'($urandom());
    end
    return it;
  endfunction

  task automatic field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(fcpa_out_t got);
    fcpa_out_t want;
    if (result_fifo.size() == 0) begin
      $display("%0t: result beat with nothing pending, expected none, got %p", $time, got);
      mismatches++;
    end else begin
      want = result_fifo.pop_front();
      field_diff("status", 32'(want.status), 32'(got.status));
      field_diff("chunk_address", want.chunk_address, got.chunk_address);
      field_diff("free_chunks", 32'(want.free_chunks), 32'(got.free_chunks));
      field_diff("pool_full", 32'(want.pool_full), 32'(got.pool_full));
      field_diff("pool_empty", 32'(want.pool_empty), 32'(got.pool_empty));
      field_diff("allocated_bytes", 32'(want.allocated_bytes), 32'(got.allocated_bytes));
    end
  endtask

  task automatic send_item(fcpa_in_t it, bit typed, fcpa_out_t typed_res);
    int        gap;
    fcpa_out_t pred;
    gap = (sent_items % 128 < 32) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = pool_step(it);
    result_fifo.push_back(typed ? typed_res : pred);
    sent_items++;
    if (it.operation == OP_ALLOC && pred.status == ST_OK) live_chunks.push_back(pred.chunk_address);
    if (it.operation == OP_REBUILD) live_chunks.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);
    // Margin for the divider of a free that might still be winding down.
    repeat (20) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    set_reg(idx, val);
  endtask

  task automatic program_pool(pool_cfg_t c);
    put_reg(CFG_BASE, c.base);
    put_reg(CFG_BYTES, DATA_W'(c.bytes));
    put_reg(CFG_COUNT, DATA_W'(c.count));
    put_reg(CFG_ALIGN, DATA_W'(c.align));
    cfg_we <= 1'b0;
    live_chunks.delete();
  endtask

  initial begin : request_source
    pool_cfg_t pc;
    cfg_base = '0;
    cfg_bytes = BYTES_W'(64);
    cfg_count = CNT_W'(1024);
    cfg_align = BYTES_W'(4);
    rebuild_pool();

    // Reset geometry: 64-byte chunks, 1024 of them, at address zero.
    dir_tab.push_back(typed_row(OP_ALLOC, 64, 4, '0, outcome(ST_OK, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_ALLOC, 65, 4, '0, outcome(ST_TOO_BIG, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_ALLOC, 0, 8, '0, outcome(ST_BAD_ALIGN, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_ALLOC, 65, 8, '0, outcome(ST_TOO_BIG, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'd64,
                                outcome(ST_DOUBLE_FREE, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'd65536,
                                outcome(ST_OUTSIDE, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'd32,
                                outcome(ST_NOT_BOUNDARY, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'hFFFF_FFFF,
                                outcome(ST_OUTSIDE, '0, 1023, 0, 0, 64)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'd0, outcome(ST_OK, '0, 1024, 0, 1, 0)));
    // Every chunk is free already, so any further free is refused.
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'd128,
                                outcome(ST_DOUBLE_FREE, '0, 1024, 0, 1, 0)));
    dir_tab.push_back(typed_row(OP_UNKNOWN, 8191, 8191, 32'hFFFF_FFFF,
                                outcome(ST_OK, '0, 1024, 0, 1, 0)));
    dir_tab.push_back(typed_row(OP_ALLOC, 4096, 4, '0, outcome(ST_TOO_BIG, '0, 1024, 0, 1, 0)));
    dir_tab.push_back(typed_row(OP_REBUILD, 0, 0, '0, outcome(ST_OK, '0, 1024, 0, 1, 0)));
    // Size and count below range clamp to one four-byte chunk at the top address.
    dir_tab.push_back(cfg_row(32'hFFFF_FFFF, 0, 0, 0));
    dir_tab.push_back(typed_row(OP_ALLOC, 4, 0, '0,
                                outcome(ST_OK, 32'hFFFF_FFFF, 0, 1, 0, 4)));
    dir_tab.push_back(typed_row(OP_ALLOC, 4, 0, '0, outcome(ST_NO_SPACE, '0, 0, 1, 0, 4)));
    dir_tab.push_back(typed_row(OP_ALLOC, 5, 0, '0, outcome(ST_TOO_BIG, '0, 0, 1, 0, 4)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'hFFFF_FFFF, outcome(ST_OK, '0, 1, 0, 1, 0)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'd3, outcome(ST_OUTSIDE, '0, 1, 0, 1, 0)));
    // Size and count above range clamp to the largest pool.
    dir_tab.push_back(cfg_row(32'hFFC0_0000, 8191, 2047, 8191));
    dir_tab.push_back(typed_row(OP_ALLOC, 4096, 8191, '0,
                                outcome(ST_OK, 32'hFFC0_0000, 1023, 0, 0, 4096)));
    dir_tab.push_back(typed_row(OP_ALLOC, 4097, 8191, '0,
                                outcome(ST_TOO_BIG, '0, 1023, 0, 0, 4096)));
    dir_tab.push_back(typed_row(OP_ALLOC, 4096, 4096, '0,
                                outcome(ST_BAD_ALIGN, '0, 1023, 0, 0, 4096)));
    dir_tab.push_back(item_row(OP_FREE, 0, 0, 32'hFFFF_F000));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'hFFFF_F800,
                                outcome(ST_NOT_BOUNDARY, '0, 1024, 0, 1, 0)));
    dir_tab.push_back(typed_row(OP_FREE, 0, 0, 32'hFFBF_FFFF,
                                outcome(ST_OUTSIDE, '0, 1024, 0, 1, 0)));
    dir_tab.push_back(item_row(OP_REBUILD, 0, 0, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_drained();
        program_pool(dir_tab[i].geo);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].result);
      end
    end

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: pc = '{32'h0000_1000, 13'd64, 11'd8, 13'd4};
        1: pc = '{32'hFFFF_FFF0, 13'd16, 11'd5, 13'd16};
        2: pc = '{$urandom(), BYTES_W'($urandom_range(4, 4096)),
                  CNT_W'($urandom_range(1, 32)), BYTES_W'($urandom_range(1, 4096))};
        3: pc = '{32'h0000_0000, 13'd4, 11'd1, 13'd1};
        4: pc = '{$urandom(), 13'd4096, 11'd1024, 13'd4096};
        5: pc = '{$urandom(), 13'd8191, 11'd0, 13'd8191};
        6: pc = '{$urandom(), 13'd3, 11'd2047, 13'd0};
        7: pc = '{$urandom(), BYTES_W'($urandom_range(0, 8191)),
                  CNT_W'($urandom_range(1, 16)), BYTES_W'($urandom_range(0, 8191))};
        default: pc = '{32'hFFFF_FFFF, 13'd100, 11'd3, 13'd7};
      endcase
      wait_drained();
      program_pool(pc);
      for (int n = 0; n < 100; n++) begin
        // One pause in mid-phase lets the result side run completely dry.
        if (p == 2 && n == 50) wait_drained();
        send_item(gen_item(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    forever begin
      // One long hold-off fills the block and backs up the request side.
      if (got_results == 300) gap = 400;
      else gap = (got_results % 100 < 25) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result(out_data);
      got_results++;
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
